[design/matrix_element_multiply_accumulate_top_defines.svh]
// Assertion macros for the matrix element multiply-accumulate block.
// MEMA_ASSERT checks on every clock edge outside reset.
// MEMA_ASSERT_NORST checks on every clock edge, reset included.
`ifndef MATRIX_ELEMENT_MULTIPLY_ACCUMULATE_TOP_DEFINES_SVH
`define MATRIX_ELEMENT_MULTIPLY_ACCUMULATE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MEMA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: assertion failed");
`define MEMA_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("%m: assertion failed");
`else
`define MEMA_ASSERT(lbl, clk, rstn, prop)
`define MEMA_ASSERT_NORST(lbl, clk, prop)
`endif

`endif

[design/mema_pkg.sv]
`default_nettype none

package mema_pkg;

  localparam int IDX_W   = 6;
  localparam int MAX_DIM = 1 << IDX_W;
  localparam int DIM_W   = IDX_W + 1;
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int VAL_W   = 48;
  localparam int AB_W    = 16;
  localparam int PROD_W  = 2 * AB_W;
  // C plus MAX_DIM products of PROD_W bits, with room to spare
  localparam int ACC_W   = VAL_W + IDX_W - 4;
  localparam int DIM_RESET = 64;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_LOAD_C  = 2'd2,
    OP_COMPUTE = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    COND_NEXT     = 2'd0,  // never jump
    COND_NO_START = 2'd1,  // jump while no compute request to start
    COND_K_MORE   = 2'd2,  // jump while products remain
    COND_OUT_BUSY = 2'd3   // jump while the output register is full
  } cond_e;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_RD_C   = 3'd1;
  localparam step_t STEP_LD_C   = 3'd2;
  localparam step_t STEP_MAC    = 3'd3;
  localparam step_t STEP_DRAIN1 = 3'd4;
  localparam step_t STEP_DRAIN2 = 3'd5;
  localparam step_t STEP_WAIT   = 3'd6;
  localparam step_t STEP_WB     = 3'd7;

  typedef struct packed {
    cond_e cond;
    step_t target;
    logic  idle;
    logic  rd_c;
    logic  acc_ld;
    logic  rd_ab;
    logic  k_clr;
    logic  k_inc;
    logic  wb;
  } uctrl_t;

  typedef struct packed {
    logic start;
    logic k_last;
    logic out_busy;
  } seq_status_t;

  function automatic uctrl_t ucode_rom(step_t s);
    uctrl_t w;
    w        = '0;
    w.cond   = COND_NEXT;
    w.target = STEP_IDLE;
    case (s)
      STEP_IDLE: begin
        w.idle   = 1'b1;
        w.cond   = COND_NO_START;
        w.target = STEP_IDLE;
      end
      STEP_RD_C: begin
        w.rd_c  = 1'b1;
        w.k_clr = 1'b1;
      end
      STEP_LD_C: begin
        w.acc_ld = 1'b1;
      end
      STEP_MAC: begin
        w.rd_ab  = 1'b1;
        w.k_inc  = 1'b1;
        w.cond   = COND_K_MORE;
        w.target = STEP_MAC;
      end
      STEP_DRAIN1: ;
      STEP_DRAIN2: ;
      STEP_WAIT: begin
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_WAIT;
      end
      STEP_WB: begin
        w.wb = 1'b1;  // falls through to step zero
      end
      default: begin
        w.idle = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[design/matrix_element_multiply_accumulate_top.sv]
// Channel  Direction  Handshake                 Payload
// cfg      in         cfg_valid_i / cfg_ready_o cfg_dim_in_use_i
// in       in         in_valid_i / in_ready_o   opcode_i, row_i, col_i, value_i
// out      out        out_valid_o / out_ready_i out_row_o, out_col_o, result_o, saturated_o
//
// A compute request runs a C read, then one A/B memory read and one
// product per cycle up to the last k index, the DRAIN1 and DRAIN2 steps
// of multiply/accumulate pipeline drain, then write-back into C.
// A compute outside the n x n range yields no result.
// Reset clears control only; the A, B and C memories are not cleared.
// A full output register holds the write-back step until it is taken.
`default_nettype none
`include "matrix_element_multiply_accumulate_top_defines.svh"

module matrix_element_multiply_accumulate_top (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire [mema_pkg::DIM_W-1:0]         cfg_dim_in_use_i,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire [1:0]                         opcode_i,
  input  wire [mema_pkg::IDX_W-1:0]         row_i,
  input  wire [mema_pkg::IDX_W-1:0]         col_i,
  input  wire signed [mema_pkg::VAL_W-1:0]  value_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [mema_pkg::IDX_W-1:0]        out_row_o,
  output logic [mema_pkg::IDX_W-1:0]        out_col_o,
  output logic signed [mema_pkg::VAL_W-1:0] result_o,
  output logic                              saturated_o
);
  import mema_pkg::*;

  uctrl_t                  ctrl;
  seq_status_t             status;
  logic [DIM_W-1:0]        dim_q;
  logic                    start, k_last;
  logic [IDX_W-1:0]        res_row, res_col;
  logic signed [VAL_W-1:0] res_value;
  logic                    res_sat;
  logic                    out_valid_q;
  logic [IDX_W-1:0]        out_row_q, out_col_q;
  logic signed [VAL_W-1:0] result_q;
  logic                    sat_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ctrl.idle;

  assign status.start    = start;
  assign status.k_last   = k_last;
  assign status.out_busy = out_valid_q;

  mema_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  mema_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_valid_i  (in_valid_i),
    .opcode_i    (opcode_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .value_i     (value_i),
    .dim_i       (dim_q),
    .start_o     (start),
    .k_last_o    (k_last),
    .res_row_o   (res_row),
    .res_col_o   (res_col),
    .res_value_o (res_value),
    .res_sat_o   (res_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q       <= DIM_W'(DIM_RESET);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        dim_q <= cfg_dim_in_use_i;
      end
      if (ctrl.wb) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.wb) begin
      out_row_q <= res_row;
      out_col_q <= res_col;
      result_q  <= res_value;
      sat_q     <= res_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign result_o    = result_q;
  assign saturated_o = sat_q;

  `MEMA_ASSERT(a_wb_into_free_reg, clk_i, rst_ni, ctrl.wb |-> !out_valid_q)
  `MEMA_ASSERT(a_out_from_wb, clk_i, rst_ni, $rose(out_valid_q) |-> $past(ctrl.wb))
  `MEMA_ASSERT_NORST(a_rst_quiet, clk_i, !rst_ni |=> !out_valid_o)

endmodule

`default_nettype wire

[design/mema_seq.sv]
`default_nettype none
`include "matrix_element_multiply_accumulate_top_defines.svh"

module mema_seq (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  mema_pkg::seq_status_t     status_i,
  output mema_pkg::uctrl_t          ctrl_o
);
  import mema_pkg::*;

  step_t  pc_q, pc_d;
  uctrl_t ctrl;
  logic   jump;

  assign ctrl   = ucode_rom(pc_q);
  assign ctrl_o = ctrl;

  always_comb begin
    case (ctrl.cond)
      COND_NEXT:     jump = 1'b0;
      COND_NO_START: jump = !status_i.start;
      COND_K_MORE:   jump = !status_i.k_last;
      COND_OUT_BUSY: jump = status_i.out_busy;
      default:       jump = 1'b0;
    endcase
    pc_d = jump ? ctrl.target : pc_q + STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  `MEMA_ASSERT(a_mac_exit, clk_i, rst_ni,
    (pc_q == STEP_MAC) && status_i.k_last |=> (pc_q == STEP_DRAIN1))

endmodule

`default_nettype wire

[design/mema_datapath.sv]
`default_nettype none
`include "matrix_element_multiply_accumulate_top_defines.svh"

module mema_datapath (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  mema_pkg::uctrl_t             ctrl_i,
  input  wire                          in_valid_i,
  input  wire [1:0]                    opcode_i,
  input  wire [mema_pkg::IDX_W-1:0]    row_i,
  input  wire [mema_pkg::IDX_W-1:0]    col_i,
  input  wire signed [mema_pkg::VAL_W-1:0] value_i,
  input  wire [mema_pkg::DIM_W-1:0]    dim_i,
  output logic                         start_o,
  output logic                         k_last_o,
  output logic [mema_pkg::IDX_W-1:0]   res_row_o,
  output logic [mema_pkg::IDX_W-1:0]   res_col_o,
  output logic signed [mema_pkg::VAL_W-1:0] res_value_o,
  output logic                         res_sat_o
);
  import mema_pkg::*;

  logic signed [AB_W-1:0]   a_mem [DEPTH];
  logic signed [AB_W-1:0]   b_mem [DEPTH];
  logic signed [VAL_W-1:0]  c_mem [DEPTH];

  logic [IDX_W-1:0]         r_q, c_q, k_q;
  logic [DIM_W-1:0]         dim_eff;
  logic [IDX_W-1:0]         nm1;
  logic                     in_fire;
  logic signed [AB_W-1:0]   value_sat;
  logic signed [AB_W-1:0]   a_rd_q, b_rd_q;
  logic signed [VAL_W-1:0]  c_rd_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     v1_q, v2_q;
  logic                     c_we;
  logic [ADDR_W-1:0]        c_waddr;
  logic signed [VAL_W-1:0]  c_wdata;
  logic                     acc_ovf;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  assign in_fire = in_valid_i && ctrl_i.idle;

  // zero is taken as one, anything above the built size as the built size
  always_comb begin
    if (dim_i == '0) begin
      dim_eff = DIM_W'(1);
    end else if (dim_i > DIM_W'(MAX_DIM)) begin
      dim_eff = DIM_W'(MAX_DIM);
    end else begin
      dim_eff = dim_i;
    end
  end
  assign nm1 = IDX_W'(dim_eff - DIM_W'(1));

  assign start_o  = in_valid_i && (opcode_i == OP_COMPUTE) && (row_i <= nm1) && (col_i <= nm1);
  assign k_last_o = (k_q == nm1);

  // A and B clamp to 16 bits on load
  always_comb begin
    if (value_i[VAL_W-1:AB_W-1] == '0 || value_i[VAL_W-1:AB_W-1] == '1) begin
      value_sat = value_i[AB_W-1:0];
    end else if (value_i[VAL_W-1]) begin
      value_sat = {1'b1, {(AB_W-1){1'b0}}};
    end else begin
      value_sat = {1'b0, {(AB_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && opcode_i == OP_LOAD_A) begin
      a_mem[{row_i, col_i}] <= value_sat;
    end
    if (ctrl_i.rd_ab) begin
      a_rd_q <= a_mem[{r_q, k_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && opcode_i == OP_LOAD_B) begin
      b_mem[{row_i, col_i}] <= value_sat;
    end
    if (ctrl_i.rd_ab) begin
      b_rd_q <= b_mem[{k_q, c_q}];
    end
  end

  // saturate the wide sum once, at write-back
  assign acc_ovf = !(acc_q[ACC_W-1:VAL_W-1] == '0 || acc_q[ACC_W-1:VAL_W-1] == '1);
  always_comb begin
    if (!acc_ovf) begin
      res_value_o = acc_q[VAL_W-1:0];
    end else if (acc_q[ACC_W-1]) begin
      res_value_o = VAL_MIN;
    end else begin
      res_value_o = VAL_MAX;
    end
  end
  assign res_sat_o = acc_ovf;
  assign res_row_o = r_q;
  assign res_col_o = c_q;

  assign c_we    = ctrl_i.wb || (in_fire && opcode_i == OP_LOAD_C);
  assign c_waddr = ctrl_i.wb ? {r_q, c_q} : {row_i, col_i};
  assign c_wdata = ctrl_i.wb ? res_value_o : value_i;

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      c_mem[c_waddr] <= c_wdata;
    end
    if (ctrl_i.rd_c) begin
      c_rd_q <= c_mem[{r_q, c_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      r_q <= row_i;
      c_q <= col_i;
    end
    if (v1_q) begin
      prod_q <= a_rd_q * b_rd_q;
    end
    if (ctrl_i.acc_ld) begin
      acc_q <= ACC_W'(c_rd_q);
    end else if (v2_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ctrl_i.k_clr) begin
        k_q <= '0;
      end else if (ctrl_i.k_inc) begin
        k_q <= k_q + IDX_W'(1);
      end
      v1_q <= ctrl_i.rd_ab;
      v2_q <= v1_q;
    end
  end

  `MEMA_ASSERT(a_idle_pipe_empty, clk_i, rst_ni,
    ctrl_i.idle |-> !v1_q && !v2_q)
  `MEMA_ASSERT(a_sat_clamps, clk_i, rst_ni,
    ctrl_i.wb && res_sat_o |-> (res_value_o == VAL_MAX) || (res_value_o == VAL_MIN))

endmodule

`default_nettype wire
